// File: rtl/gip_message_reassembler_assert.svh
// assertion macros for the gip message reassembler
// depends on nothing; included by the files that assert
`ifndef GIP_MESSAGE_REASSEMBLER_ASSERT_SVH
`define GIP_MESSAGE_REASSEMBLER_ASSERT_SVH
`ifndef SYNTHESIS
`define GMR_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define GMR_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define GMR_ASSERT_IMP(label, clk, rst, a, c)
`define GMR_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/gmr_pkg.sv
// types and constants shared by the gip message reassembler
// no dependencies
package gmr_pkg;
  localparam int DATA_BYTES = 1024;
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_ACK  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] ST_ACCEPT = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_SHORT  = 2'd2;
  localparam logic [7:0] F_CHUNKED  = 8'h80;
  localparam logic [7:0] F_START    = 8'h40;
  localparam logic [7:0] F_INTERNAL = 8'h20;
  localparam logic [7:0] F_ACK      = 8'h10;
  localparam logic [7:0] ACK_CMD     = 8'h01;
  localparam logic [7:0] ACK_PAYLOAD = 8'd9;
  localparam int ACK_LEN = 13;
  localparam int HDR_LEN = 6;

  // job handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic        judge;
    logic [7:0]  len;
    logic [10:0] rd_index;
  } job_t;

  // result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic        complete;
    logic        ack_req;
    logic [7:0]  mtype;
    logic [7:0]  seq;
    logic [10:0] recv;
    logic [10:0] remain;
    logic [7:0]  data;
    logic        last;
  } res_t;
endpackage

// File: rtl/gip_message_reassembler.sv
// gip message reassembler top level: front capture, back judge, result queue
// a status result passes the front job register, back result register and result queue; a data
// result also passes the back read stage; ack bytes follow one per cycle while there is room
// throughput: a packet byte that is not the last goes every cycle while the queue has room;
// an item that forms a job blocks the next cycle; an ack holds the input until its last byte is sent
// reset: synchronous, clears message state; the data store is not cleared
module gip_message_reassembler #(
  parameter int CHUNK_BYTES = 58,
  parameter int MAX_PACKET = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  input  logic [9:0]  read_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [1:0]  status,
  output logic        message_complete,
  output logic        ack_required,
  output logic [7:0]  message_type,
  output logic [7:0]  sequence_number,
  output logic [10:0] received_length,
  output logic [10:0] remaining_length,
  output logic [7:0]  out_byte,
  output logic        last_result
);
  localparam int QD = 8;
  logic          take, job_valid, res_valid, busy, rd_q, room;
  gmr_pkg::job_t job;
  gmr_pkg::res_t res, head;
  logic [7:0]    hdr [6];
  logic [7:0]    rd_data;
  logic [10:0]   stored_len;
  logic [$clog2(QD):0] count;
  logic [2:0]    inflight;

  // room for everything already in the pipe plus one more
  assign full = busy || job_valid || (32'(count) + 32'(inflight) > QD - 3);
  assign take = push && !full;
  assign rd_q = pop && !empty;
  // space for one more ack byte beside the one in the result register
  assign room = (32'(count) + 32'(res_valid)) < QD;

  // track a transfer still in the front job register
  always_ff @(posedge clk) begin
    if (rst) inflight <= '0;
    else inflight <= {2'd0, take};
  end

  gmr_front #(.CHUNK_BYTES(CHUNK_BYTES), .MAX_PACKET(MAX_PACKET)) u_front (
    .clk(clk), .rst(rst), .take(take), .command(command), .byte_value(byte_value),
    .last_byte(last_byte), .read_index(read_index), .stored_len(stored_len),
    .job_valid(job_valid), .job(job), .hdr(hdr), .rd_data(rd_data)
  );

  gmr_back #(.CHUNK_BYTES(CHUNK_BYTES), .MAX_PACKET(MAX_PACKET)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .hdr(hdr),
    .rd_data(rd_data), .room(room), .stored_len(stored_len), .res_valid(res_valid),
    .res(res), .busy(busy)
  );

  gmr_fifo #(.DEPTH(QD)) u_fifo (
    .clk(clk), .rst(rst), .wr(res_valid), .wdata(res), .rd(rd_q),
    .rdata(head), .empty(empty), .count(count)
  );

  // result fields
  assign kind = head.kind;
  assign status = head.status;
  assign message_complete = head.complete;
  assign ack_required = head.ack_req;
  assign message_type = head.mtype;
  assign sequence_number = head.seq;
  assign received_length = head.recv;
  assign remaining_length = head.remain;
  assign out_byte = head.data;
  assign last_result = head.last;
endmodule

// File: rtl/gmr_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
module gmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/gmr_fifo.sv
// small result queue with an empty flag and a count
// depends on gmr_pkg
module gmr_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  gmr_pkg::res_t wdata,
  input  logic          rd,
  output gmr_pkg::res_t rdata,
  output logic          empty,
  output logic [$clog2(DEPTH):0] count
);
  localparam int AW = $clog2(DEPTH);
  gmr_pkg::res_t buffer [DEPTH];
  logic [AW-1:0] wptr, rptr;

  assign rdata = buffer[rptr];
  assign empty = (count == '0);

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      count <= count + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) buffer[wptr] <= wdata;
  end
endmodule

// File: rtl/gmr_front.sv
// front part: captures packet bytes, writes payload, classifies items into jobs
// depends on gmr_pkg, gmr_ram and the assertion header
`include "gip_message_reassembler_assert.svh"
module gmr_front #(
  parameter int CHUNK_BYTES = 58,
  parameter int MAX_PACKET = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic [1:0]        command,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  input  logic [9:0]        read_index,
  input  logic [10:0]       stored_len,
  output logic              job_valid,
  output gmr_pkg::job_t     job,
  output logic [7:0]        hdr [6],
  output logic [7:0]        rd_data
);
  localparam int AW = $clog2(gmr_pkg::DATA_BYTES);
  logic [7:0] seen;
  logic [7:0] seen_next;
  logic [7:0] h [6];
  logic [7:0] pl, fl, cl;
  logic       we;
  logic [11:0] p;
  logic [16:0] waddr_full;
  logic [AW-1:0] raddr;

  assign hdr = h;

  // header view including the byte arriving now
  always_comb begin
    fl = (seen == 8'd1) ? byte_value : h[1];
    pl = (seen == 8'd3) ? byte_value : h[3];
    cl = (pl > 8'(CHUNK_BYTES)) ? (pl ^ gmr_pkg::F_CHUNKED) : pl;
  end

  // payload write decision
  always_comb begin
    we = 1'b0;
    p = '0;
    waddr_full = '0;
    if (take && command == gmr_pkg::CMD_BYTE && seen >= 8'd4 &&
        seen < 8'(MAX_PACKET) && h[0] != gmr_pkg::ACK_CMD) begin
      if ((fl & gmr_pkg::F_CHUNKED) == 8'h00) begin
        p = 12'(seen) - 12'd4;
        waddr_full = 17'(p);
        we = (p < 12'(pl)) && (17'(p) < 17'(gmr_pkg::DATA_BYTES));
      end else if (pl != 8'h00 && seen >= 8'(gmr_pkg::HDR_LEN)) begin
        p = 12'(seen) - 12'(gmr_pkg::HDR_LEN);
        waddr_full = ((fl & gmr_pkg::F_START) != 8'h00) ? 17'(p)
                     : 17'(stored_len) + 17'(p);
        we = (p < 12'(cl)) && (waddr_full < 17'(gmr_pkg::DATA_BYTES));
      end
    end
  end

  // read address follows the input on a transfer and holds the job index after it
  assign raddr = take ? AW'(read_index) : AW'(job.rd_index);
  assign seen_next = (seen <= 8'(MAX_PACKET)) ? seen + 8'd1 : seen;

  gmr_ram #(.WIDTH(8), .DEPTH(gmr_pkg::DATA_BYTES)) u_store (
    .clk(clk), .we(we), .waddr(waddr_full[AW-1:0]), .wdata(byte_value),
    .raddr(raddr), .rdata(rd_data)
  );

  // capture and job register
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      job_valid <= 1'b0;
      for (int i = 0; i < 6; i++) h[i] <= '0;
    end else begin
      job_valid <= 1'b0;
      if (take) begin
        job.op <= command;
        job.rd_index <= {1'b0, read_index};
        job.len <= seen_next;
        job.judge <= last_byte;
        unique case (command)
          gmr_pkg::CMD_BYTE: begin
            if (seen < 8'(gmr_pkg::HDR_LEN)) h[seen[2:0]] <= byte_value;
            seen <= last_byte ? 8'd0 : seen_next;
            job_valid <= last_byte;
          end
          gmr_pkg::CMD_READ, gmr_pkg::CMD_ACK: job_valid <= 1'b1;
          default: job_valid <= 1'b0;
        endcase
      end
    end
  end

  `GMR_ASSERT_IMP(a_seen_bound, clk, rst, 1'b1, seen <= 8'(MAX_PACKET) + 8'd1)
  `GMR_ASSERT_NXT(a_last_clears, clk, rst,
    take && command == gmr_pkg::CMD_BYTE && last_byte, seen == 8'd0 && job_valid)
  `GMR_ASSERT_NXT(a_idle_no_job, clk, rst, !take, !job_valid)
endmodule

// File: rtl/gmr_back.sv
// back part: judges packets, keeps message state and produces result items
// depends on gmr_pkg and the assertion header
`include "gip_message_reassembler_assert.svh"
module gmr_back #(
  parameter int CHUNK_BYTES = 58,
  parameter int MAX_PACKET = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  gmr_pkg::job_t job,
  input  logic [7:0]    hdr [6],
  input  logic [7:0]    rd_data,
  input  logic          room,
  output logic [10:0]   stored_len,
  output logic          res_valid,
  output gmr_pkg::res_t res,
  output logic          busy
);
  logic [7:0]  cur_type, cur_flags, cur_seq;
  logic        msg_valid, complete, chunked;
  logic [15:0] enc_total, exp_total;
  logic [10:0] stored;
  logic [3:0]  ack_idx;
  logic        acking;
  logic [7:0]  ack_pkt [13];

  // next message state from judging
  logic [7:0]  t_n, f_n, s_n;
  logic        v_n, c_n, ch_n;
  logic [15:0] e_n, x_n;
  logic [10:0] l_n;
  logic [1:0]  st;
  logic [7:0]  t, f, sq, pl, cl;
  logic [15:0] word, d0, dec;
  logic [16:0] sum;

  assign stored_len = stored;
  assign busy = acking;

  // total length decode and header fields
  always_comb begin
    t = hdr[0]; f = hdr[1]; sq = hdr[2]; pl = hdr[3];
    word = {hdr[5], hdr[4]};
    cl = (pl > 8'(CHUNK_BYTES)) ? (pl ^ gmr_pkg::F_CHUNKED) : pl;
    d0 = word - 16'h0100;
    dec = (word > 16'h0100) ? d0 - {1'b0, d0[15:8], 7'd0} : word;
  end

  // packet judgement
  always_comb begin
    t_n = cur_type; f_n = cur_flags; s_n = cur_seq;
    v_n = msg_valid; c_n = complete; ch_n = chunked;
    e_n = enc_total; x_n = exp_total; l_n = stored;
    st = gmr_pkg::ST_ACCEPT;
    sum = '0;
    if (job.len < 8'd4) begin
      st = gmr_pkg::ST_SHORT;
    end else if (job.len > 8'(MAX_PACKET)) begin
      st = gmr_pkg::ST_REJECT;
    end else if (t == gmr_pkg::ACK_CMD) begin
      if (job.len != 8'(gmr_pkg::ACK_LEN) || (f & gmr_pkg::F_INTERNAL) == 8'h00 ||
          pl != gmr_pkg::ACK_PAYLOAD) begin
        st = gmr_pkg::ST_REJECT;
      end else begin
        t_n = t; f_n = f; s_n = sq; v_n = 1'b1; c_n = 1'b1;
        ch_n = 1'b0; e_n = '0; x_n = '0; l_n = '0;
      end
    end else if ((f & gmr_pkg::F_CHUNKED) == 8'h00) begin
      if (9'(pl) + 9'd4 > 9'(job.len) || 17'(pl) > 17'(gmr_pkg::DATA_BYTES)) begin
        st = gmr_pkg::ST_REJECT;
      end else begin
        t_n = t; f_n = f; s_n = sq; v_n = 1'b1; c_n = 1'b1;
        ch_n = 1'b0; e_n = '0; x_n = '0; l_n = 11'(pl);
      end
    end else if (pl == 8'h00) begin
      if (job.len < 8'(gmr_pkg::HDR_LEN) || !msg_valid || !chunked ||
          word != enc_total || 16'(stored) != exp_total) begin
        st = gmr_pkg::ST_REJECT;
      end else begin
        f_n = f; s_n = sq; c_n = 1'b1;
      end
    end else if (9'(cl) + 9'(gmr_pkg::HDR_LEN) > 9'(job.len)) begin
      st = gmr_pkg::ST_REJECT;
    end else if ((f & gmr_pkg::F_START) != 8'h00) begin
      sum = 17'(cl);
      if (17'(dec) > 17'(gmr_pkg::DATA_BYTES) || sum > 17'(gmr_pkg::DATA_BYTES)) begin
        st = gmr_pkg::ST_REJECT;
      end else begin
        t_n = t; f_n = f; s_n = sq; v_n = 1'b1; c_n = 1'b0; ch_n = 1'b1;
        e_n = word; x_n = dec; l_n = 11'(sum);
      end
    end else begin
      sum = 17'(stored) + 17'(cl);
      if (!msg_valid || !chunked || cur_type != t ||
          sum > 17'(gmr_pkg::DATA_BYTES)) begin
        st = gmr_pkg::ST_REJECT;
      end else begin
        f_n = f; s_n = sq; c_n = 1'b0; l_n = 11'(sum);
      end
    end
    if (st == gmr_pkg::ST_REJECT) begin
      t_n = '0; f_n = '0; s_n = '0; v_n = 1'b0; c_n = 1'b0; ch_n = 1'b0;
      e_n = '0; x_n = '0; l_n = '0;
    end
  end

  // snapshot of message state for the result fields
  logic [10:0] remain;
  always_comb begin
    remain = (chunked && exp_total > 16'(stored)) ? 11'(exp_total - 16'(stored)) : '0;
    ack_pkt[0] = gmr_pkg::ACK_CMD;    ack_pkt[1] = gmr_pkg::F_INTERNAL;
    ack_pkt[2] = cur_seq;             ack_pkt[3] = gmr_pkg::ACK_PAYLOAD;
    ack_pkt[4] = 8'h00;               ack_pkt[5] = cur_type;
    ack_pkt[6] = gmr_pkg::F_INTERNAL; ack_pkt[7] = stored[7:0];
    ack_pkt[8] = {5'd0, stored[10:8]}; ack_pkt[9] = 8'h00;
    ack_pkt[10] = 8'h00;              ack_pkt[11] = remain[7:0];
    ack_pkt[12] = {5'd0, remain[10:8]};
  end

  // the read job sees registered ram data in the cycle after the request
  logic rd_pend;
  logic [10:0] rd_idx;

  // message state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_type <= '0; cur_flags <= '0; cur_seq <= '0;
      msg_valid <= 1'b0; complete <= 1'b0; chunked <= 1'b0;
      enc_total <= '0; exp_total <= '0; stored <= '0;
      acking <= 1'b0; ack_idx <= '0; res_valid <= 1'b0; rd_pend <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      rd_pend <= 1'b0;
      res.complete <= complete;
      res.ack_req <= msg_valid && ((cur_flags & gmr_pkg::F_ACK) != 8'h00);
      res.mtype <= cur_type; res.seq <= cur_seq;
      res.recv <= stored; res.remain <= remain;
      res.status <= gmr_pkg::ST_ACCEPT;
      res.data <= '0;
      res.last <= 1'b1;
      if (acking) begin
        // ack bytes wait while the result queue has no room
        if (room) begin
          res_valid <= 1'b1;
          res.kind <= gmr_pkg::KIND_ACK;
          res.data <= ack_pkt[ack_idx];
          res.last <= (ack_idx == 4'(gmr_pkg::ACK_LEN - 1));
          ack_idx <= ack_idx + 4'd1;
          if (ack_idx == 4'(gmr_pkg::ACK_LEN - 1)) acking <= 1'b0;
        end
      end else if (rd_pend) begin
        res_valid <= 1'b1;
        res.kind <= gmr_pkg::KIND_DATA;
        res.data <= (rd_idx < stored) ? rd_data : 8'h00;
      end else if (job_valid) begin
        unique case (job.op)
          gmr_pkg::CMD_BYTE: begin
            res_valid <= 1'b1;
            res.kind <= gmr_pkg::KIND_STATUS;
            res.status <= st;
            res.complete <= c_n;
            res.ack_req <= v_n && ((f_n & gmr_pkg::F_ACK) != 8'h00);
            res.mtype <= t_n; res.seq <= s_n; res.recv <= l_n;
            res.remain <= (ch_n && x_n > 16'(l_n)) ? 11'(x_n - 16'(l_n)) : '0;
            cur_type <= t_n; cur_flags <= f_n; cur_seq <= s_n;
            msg_valid <= v_n; complete <= c_n; chunked <= ch_n;
            enc_total <= e_n; exp_total <= x_n; stored <= l_n;
          end
          gmr_pkg::CMD_READ: begin
            rd_pend <= 1'b1;
            rd_idx <= job.rd_index;
          end
          gmr_pkg::CMD_ACK: begin
            if (msg_valid) begin
              acking <= 1'b1;
              ack_idx <= '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  `GMR_ASSERT_IMP(a_ack_idx, clk, rst, acking, ack_idx < 4'(gmr_pkg::ACK_LEN))
  `GMR_ASSERT_IMP(a_stored_bound, clk, rst, 1'b1, 17'(stored) <= 17'(gmr_pkg::DATA_BYTES))
  `GMR_ASSERT_NXT(a_read_result, clk, rst, rd_pend && !acking, res_valid)
endmodule

// File: verif/gip_message_reassembler_tb.sv
// self-checking testbench for the gip message reassembler: packets, reads and ack requests
// are driven through the queue handshake and every result is checked against a local predictor
// depends on gmr_pkg and the gip_message_reassembler rtl
module gip_message_reassembler_tb;
  localparam int DATA_BYTES  = 1024;
  localparam int CHUNK_BYTES = 58;
  localparam int MAX_PACKET  = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 50;
  localparam logic [1:0] CMD_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  command = gmr_pkg::CMD_BYTE;
  logic [7:0]  byte_value = '0;
  logic        last_byte = 1'b0;
  logic [9:0]  read_index = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind;
  logic [1:0]  status;
  logic        message_complete;
  logic        ack_required;
  logic [7:0]  message_type;
  logic [7:0]  sequence_number;
  logic [10:0] received_length;
  logic [10:0] remaining_length;
  logic [7:0]  out_byte;
  logic        last_result;

  gip_message_reassembler dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  store_mem [DATA_BYTES];
  int          seen_count;
  logic [7:0]  hdr [gmr_pkg::HDR_LEN];
  logic [7:0]  cur_type, cur_flags, cur_seq;
  logic        msg_valid, msg_complete, msg_chunked;
  logic [15:0] enc_total;
  int          exp_total, stored_len;

  gmr_pkg::res_t expected_results [$];
  int   error_count = 0;
  int   cycle_count = 0;
  int   sent_count = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  function automatic void clear_msg();
    cur_type = '0; cur_flags = '0; cur_seq = '0;
    msg_valid = 1'b0; msg_complete = 1'b0; msg_chunked = 1'b0;
    enc_total = '0; exp_total = 0; stored_len = 0;
  endfunction

  function automatic int decode_len(logic [15:0] e);
    int d;
    d = e;
    if (d > 'h100) begin
      d -= 'h100;
      d -= (d / 'h100) * 'h80;
    end
    return d;
  endfunction

  function automatic int chunk_len(int pl);
    return (pl > CHUNK_BYTES) ? ((pl ^ 'h80) & 'hff) : pl;
  endfunction

  function automatic int remaining_now();
    return (msg_chunked && exp_total > stored_len) ? exp_total - stored_len : 0;
  endfunction

  function automatic void add_result(logic [1:0] k, logic [1:0] st, logic [7:0] b,
                                     logic fin);
    gmr_pkg::res_t r;
    r.kind = k; r.status = st; r.complete = msg_complete;
    r.ack_req = msg_valid && ((cur_flags & gmr_pkg::F_ACK) != 0);
    r.mtype = cur_type; r.seq = cur_seq;
    r.recv = stored_len[10:0]; r.remain = 11'(remaining_now());
    r.data = b; r.last = fin;
    expected_results.push_back(r);
  endfunction

  // packet judgement on the last byte
  function automatic logic [1:0] judge_packet(int len);
    logic [7:0] t, f, sq;
    int pl, cl;
    logic [15:0] w;
    t = hdr[0]; f = hdr[1]; sq = hdr[2]; pl = hdr[3]; w = {hdr[5], hdr[4]};
    if (len < 4) return gmr_pkg::ST_SHORT;
    if (len > MAX_PACKET) begin clear_msg(); return gmr_pkg::ST_REJECT; end
    if (t == gmr_pkg::ACK_CMD) begin
      clear_msg();
      if (len != gmr_pkg::ACK_LEN || (f & gmr_pkg::F_INTERNAL) == 0 ||
          pl != gmr_pkg::ACK_PAYLOAD) return gmr_pkg::ST_REJECT;
      cur_type = t; cur_flags = f; cur_seq = sq;
      msg_valid = 1'b1; msg_complete = 1'b1;
      return gmr_pkg::ST_ACCEPT;
    end
    if ((f & gmr_pkg::F_CHUNKED) == 0) begin
      clear_msg();
      if (pl + 4 > len || pl > DATA_BYTES) return gmr_pkg::ST_REJECT;
      cur_type = t; cur_flags = f; cur_seq = sq;
      msg_valid = 1'b1; msg_complete = 1'b1; stored_len = pl;
      return gmr_pkg::ST_ACCEPT;
    end
    if (pl == 0) begin
      if (len < gmr_pkg::HDR_LEN || !msg_valid || !msg_chunked || w != enc_total ||
          stored_len != exp_total) begin
        clear_msg();
        return gmr_pkg::ST_REJECT;
      end
      cur_flags = f; cur_seq = sq; msg_complete = 1'b1;
      return gmr_pkg::ST_ACCEPT;
    end
    cl = chunk_len(pl);
    if (cl + gmr_pkg::HDR_LEN > len) begin clear_msg(); return gmr_pkg::ST_REJECT; end
    if ((f & gmr_pkg::F_START) != 0) begin
      clear_msg();
      cur_type = t; cur_seq = sq; msg_chunked = 1'b1;
      enc_total = w; exp_total = decode_len(w);
      if (exp_total > DATA_BYTES) begin clear_msg(); return gmr_pkg::ST_REJECT; end
      msg_valid = 1'b1;
    end else if (!msg_valid || !msg_chunked || cur_type != t) begin
      clear_msg();
      return gmr_pkg::ST_REJECT;
    end
    if (stored_len + cl > DATA_BYTES) begin clear_msg(); return gmr_pkg::ST_REJECT; end
    stored_len += cl;
    cur_flags = f; cur_seq = sq; msg_complete = 1'b0;
    return gmr_pkg::ST_ACCEPT;
  endfunction

  // byte capture into header and tentative payload
  function automatic void capture_byte(int idx, logic [7:0] b);
    int p, a, pl;
    logic [7:0] f;
    if (idx < gmr_pkg::HDR_LEN) hdr[idx] = b;
    if (idx < 4 || idx >= MAX_PACKET || hdr[0] == gmr_pkg::ACK_CMD) return;
    f = hdr[1]; pl = hdr[3];
    if ((f & gmr_pkg::F_CHUNKED) == 0) begin
      p = idx - 4;
      if (p < pl && p < DATA_BYTES) store_mem[p] = b;
      return;
    end
    if (pl == 0 || idx < gmr_pkg::HDR_LEN) return;
    p = idx - gmr_pkg::HDR_LEN;
    if (p >= chunk_len(pl)) return;
    a = (((f & gmr_pkg::F_START) != 0) ? 0 : stored_len) + p;
    if (a < DATA_BYTES) store_mem[a] = b;
  endfunction

  // work out the results of one accepted transfer
  function automatic void predict_item(logic [1:0] cmd, logic [7:0] b, logic fin,
                                       logic [9:0] ri);
    int idx, rem;
    logic [1:0] st;
    logic [7:0] pk [gmr_pkg::ACK_LEN];
    case (cmd)
      gmr_pkg::CMD_BYTE: begin
        idx = seen_count;
        capture_byte(idx, b);
        if (idx <= MAX_PACKET) seen_count = idx + 1;
        if (fin) begin
          st = judge_packet(seen_count);
          seen_count = 0;
          add_result(gmr_pkg::KIND_STATUS, st, 8'h00, 1'b1);
        end
      end
      gmr_pkg::CMD_READ: add_result(gmr_pkg::KIND_DATA, gmr_pkg::ST_ACCEPT,
                                    (ri < stored_len) ? store_mem[ri] : 8'h00, 1'b1);
      gmr_pkg::CMD_ACK: begin
        if (msg_valid) begin
          rem = remaining_now();
          pk[0] = gmr_pkg::ACK_CMD; pk[1] = gmr_pkg::F_INTERNAL; pk[2] = cur_seq;
          pk[3] = gmr_pkg::ACK_PAYLOAD;
          pk[4] = 8'h00; pk[5] = cur_type; pk[6] = gmr_pkg::F_INTERNAL;
          pk[7] = stored_len[7:0]; pk[8] = {5'd0, stored_len[10:8]};
          pk[9] = 8'h00; pk[10] = 8'h00;
          pk[11] = rem[7:0]; pk[12] = rem[15:8];
          for (int k = 0; k < gmr_pkg::ACK_LEN; k++)
            add_result(gmr_pkg::KIND_ACK, gmr_pkg::ST_ACCEPT, pk[k],
                       k == gmr_pkg::ACK_LEN - 1);
        end
      end
      default: ;
    endcase
  endfunction

  // result check and receiver stalls
  always @(posedge clk) begin
    gmr_pkg::res_t got, want;
    cycle_count <= cycle_count + 1;
    if (!rst && pop && !empty) begin
      got = '{kind, status, message_complete, ack_required, message_type,
              sequence_number, received_length, remaining_length, out_byte,
              last_result};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  always @(negedge clk)
    pop <= !rst && ($urandom_range(99) >= recv_stall_pct);

  // one transfer: drive at the falling edge, wait for acceptance, predict
  task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic fin, logic [9:0] ri);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1; command <= cmd; byte_value <= b; last_byte <= fin; read_index <= ri;
    do @(posedge clk); while (full);
    predict_item(cmd, b, fin, ri);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_packet(logic [7:0] bytes [$]);
    foreach (bytes[i])
      send_item(gmr_pkg::CMD_BYTE, bytes[i], i == bytes.size() - 1, 10'($urandom));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // random packet of a chosen form with random content
  task automatic random_packet();
    logic [7:0] pk [$];
    int form, pl, total;
    logic [15:0] w;
    form = $urandom_range(9);
    pk = {};
    case (form)
      0: begin
        pk = {gmr_pkg::ACK_CMD, 8'(gmr_pkg::F_INTERNAL | ($urandom & 8'hdf)),
              8'($urandom), gmr_pkg::ACK_PAYLOAD};
        repeat (9) pk.push_back(8'($urandom));
        if ($urandom_range(3) == 0) pk[3] = 8'($urandom);
      end
      1, 2: begin
        pl = $urandom_range(0, 50);
        pk = {8'($urandom_range(2, 255)), 8'($urandom & 8'h7f), 8'($urandom), 8'(pl)};
        repeat (pl + $urandom_range(0, 3)) pk.push_back(8'($urandom));
      end
      3, 4: begin
        total = $urandom_range(1, 120);
        w = 16'(total);
        pl = (total < 20) ? total : $urandom_range(1, 20);
        pk = {8'h42, 8'(gmr_pkg::F_CHUNKED | gmr_pkg::F_START | ($urandom & 8'h30)),
              8'($urandom), 8'(pl), w[7:0], w[15:8]};
        repeat (pl) pk.push_back(8'($urandom));
      end
      5, 6: begin
        pl = $urandom_range(1, 20);
        pk = {8'h42, 8'(gmr_pkg::F_CHUNKED | ($urandom & 8'h30)), 8'($urandom), 8'(pl),
              8'($urandom), 8'($urandom)};
        repeat (pl) pk.push_back(8'($urandom));
      end
      7: begin
        w = enc_total;
        if ($urandom_range(3) == 0) w = 16'($urandom);
        pk = {8'h42, 8'(gmr_pkg::F_CHUNKED | ($urandom & 8'h30)), 8'($urandom), 8'h00,
              w[7:0], w[15:8]};
      end
      default: begin
        repeat ($urandom_range(1, 70)) pk.push_back(8'($urandom));
      end
    endcase
    send_packet(pk);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 70) random_packet();
    else if (r < 85)
      send_item(gmr_pkg::CMD_READ, 8'($urandom), 1'($urandom), 10'($urandom_range(0, 80)));
    else if (r < 92)
      send_item(gmr_pkg::CMD_READ, 8'($urandom), 1'($urandom), 10'($urandom));
    else if (r < 97)
      send_item(gmr_pkg::CMD_ACK, 8'($urandom), 1'($urandom), 10'($urandom));
    else send_item(CMD_NONE, 8'($urandom), 1'($urandom), 10'($urandom));
  endtask

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] b;
    logic       fin;
    logic [9:0] ri;
    logic       check_status;
    logic [1:0] want_status;
  } step_t;

  // directed table: acks, short packet, unchunked packet, reads, unknown command, bad ack form, short chunk end
  step_t directed [] = '{
    '{gmr_pkg::CMD_ACK,  8'h00, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_READ, 8'h00, 1'b0, 10'd1023, 1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'hff, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h00, 1'b1, 10'd0,    1'b1, gmr_pkg::ST_SHORT},
    '{gmr_pkg::CMD_BYTE, 8'h05, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h10, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'hff, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h02, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'hff, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h00, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h77, 1'b1, 10'd0,    1'b1, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_READ, 8'h00, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_READ, 8'h00, 1'b1, 10'd1,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_READ, 8'h00, 1'b0, 10'd2,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_ACK,  8'h00, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{CMD_NONE,          8'hff, 1'b1, 10'h3ff,  1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h01, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h20, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h09, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h09, 1'b1, 10'd0,    1'b1, gmr_pkg::ST_REJECT},
    '{gmr_pkg::CMD_BYTE, 8'h80, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h80, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h00, 1'b0, 10'd0,    1'b0, gmr_pkg::ST_ACCEPT},
    '{gmr_pkg::CMD_BYTE, 8'h00, 1'b1, 10'd0,    1'b1, gmr_pkg::ST_REJECT}
  };

  initial begin
    logic [7:0] pk [$];
    int items;
    for (int i = 0; i < DATA_BYTES; i++) store_mem[i] = '0;
    for (int i = 0; i < gmr_pkg::HDR_LEN; i++) hdr[i] = '0;
    seen_count = 0;
    clear_msg();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows, status typed in where it is plain
    foreach (directed[i]) begin
      send_item(directed[i].cmd, directed[i].b, directed[i].fin, directed[i].ri);
      if (directed[i].check_status &&
          expected_results[$].status != directed[i].want_status) begin
        $display("%0t: row %0d expected status %0d actual %0d", $time, i,
                 directed[i].want_status, expected_results[$].status);
        error_count++;
      end
    end
    // valid ack form, over-long packet, chunked message with an xor length, a further chunk and its end
    pk = {gmr_pkg::ACK_CMD, gmr_pkg::F_INTERNAL | gmr_pkg::F_ACK, 8'h33,
          gmr_pkg::ACK_PAYLOAD};
    repeat (9) pk.push_back(8'h5a);
    send_packet(pk);
    send_item(gmr_pkg::CMD_ACK, 8'h00, 1'b0, 10'd0);
    pk = {};
    repeat (70) pk.push_back(8'($urandom));
    pk[0] = 8'h07; pk[1] = 8'h00; pk[3] = 8'd10;
    send_packet(pk);
    pk = {8'h42, gmr_pkg::F_CHUNKED | gmr_pkg::F_START | gmr_pkg::F_ACK, 8'h01, 8'hba,
          8'h3a, 8'h01};
    repeat (58) pk.push_back(8'($urandom));
    send_packet(pk);
    send_item(gmr_pkg::CMD_ACK, 8'h00, 1'b0, 10'd0);
    pk = {8'h42, gmr_pkg::F_CHUNKED, 8'h02, 8'd4, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33,
          8'h44};
    send_packet(pk);
    pk = {8'h42, gmr_pkg::F_CHUNKED | gmr_pkg::F_ACK, 8'h03, 8'h00, 8'h3a, 8'h01};
    send_packet(pk);
    send_item(gmr_pkg::CMD_READ, 8'h00, 1'b0, 10'd61);
    send_item(gmr_pkg::CMD_ACK, 8'h00, 1'b0, 10'd0);
    wait_drained();

    // random phases with different idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      items = sent_count;
      while (sent_count - items < PHASE_ITEMS) random_item();
      // sender holds off until every expected result has come
      if (ph == 2) wait_drained();
    end
    wait_drained();

    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // safety limit
  always @(posedge clk)
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
endmodule
